// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ifr_pkg.sv
`default_nettype none

package ifr_pkg;

   localparam int MAX_PAYLOAD = 1024;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 3);
   localparam int LEN_W       = 11;
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FLAG      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_FLAG  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_ESC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ZERO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ONE  = 3'd6;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_FLAG = 3'd1,
      PH_ADDR = 3'd2,
      PH_CTRL = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_DATA   = 2'd0,
      EV_GOOD   = 2'd1,
      EV_REJECT = 2'd2,
      EV_DUP    = 2'd3
   } event_type;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] escape_byte;
      logic [7:0] escaped_flag_code;
      logic [7:0] escaped_escape_code;
      logic [7:0] address_value;
      logic [7:0] control_zero;
      logic [7:0] control_one;
   } config_type;

   typedef struct packed {
      event_type        event_res;
      logic [7:0]       data_byte;
      logic             reply_number;
      logic [LEN_W-1:0] payload_length;
      logic             last;
   } result_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic              room;
   } fifo_status_type;

   function automatic result_type make_data(input logic [7:0] value);
      result_type r;
      r = '0;
      r.event_res = EV_DATA;
      r.data_byte = value;
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] r;
      r = cnt;
      if (cnt < CNT_W'(MAX_PAYLOAD + 2)) begin
         r = cnt + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ifr_channels.sv
`default_nettype none

interface ifr_req_chan;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifr_rsp_chan;
   logic                     valid;
   logic                     ready;
   logic [1:0]               event_res;
   logic [7:0]               data_byte;
   logic                     reply_number;
   logic [ifr_pkg::LEN_W-1:0] payload_length;
   logic                     last;
   modport source (output valid, output event_res, output data_byte, output reply_number,
                   output payload_length, output last, input ready);
   modport sink (input valid, input event_res, input data_byte, input reply_number,
                 input payload_length, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/ifr_decoder.sv
`default_nettype none

// Frame state machine: one received byte per accepted transaction, up to two results.
module ifr_decoder (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  wire [7:0]            rx_byte,
   input  wire ifr_pkg::config_type cfg,
   output logic [1:0]           res_count,
   output ifr_pkg::result_type  res0,
   output ifr_pkg::result_type  res1
);

   ifr_pkg::phase_type          phase_ff, phase_in;
   logic                        expected_ff, expected_in;
   logic                        esc_ff, esc_in;
   logic [7:0]                  held_ff, held_in;
   logic                        held_valid_ff, held_valid_in;
   logic [7:0]                  check_ff, check_in;
   logic [ifr_pkg::CNT_W-1:0]   count_ff, count_in;

   logic [7:0]                  accept_ctrl;
   logic [7:0]                  dup_ctrl;
   logic                        frame_good;
   logic [ifr_pkg::CNT_W-1:0]   count_less_one;

   assign accept_ctrl    = expected_ff ? cfg.control_zero : cfg.control_one;
   assign dup_ctrl       = expected_ff ? cfg.control_one : cfg.control_zero;
   assign count_less_one = count_ff - ifr_pkg::CNT_W'(1);
   assign frame_good     = (check_ff == 8'd0) && (count_ff >= ifr_pkg::CNT_W'(2))
                           && (count_ff <= ifr_pkg::CNT_W'(ifr_pkg::MAX_PAYLOAD + 1));

   always_comb begin
      phase_in      = phase_ff;
      expected_in   = expected_ff;
      esc_in        = esc_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      check_in      = check_ff;
      count_in      = count_ff;
      res_count     = 2'd0;
      res0          = '0;
      res1          = '0;

      if (accept) begin
         unique case (phase_ff)
            ifr_pkg::PH_FLAG: begin
               if (rx_byte == cfg.address_value) begin
                  phase_in = ifr_pkg::PH_ADDR;
               end else if (rx_byte != cfg.flag_byte) begin
                  phase_in = ifr_pkg::PH_WAIT;
               end
            end
            ifr_pkg::PH_ADDR: begin
               if (rx_byte == accept_ctrl) begin
                  phase_in = ifr_pkg::PH_CTRL;
               end else if (rx_byte == dup_ctrl) begin
                  res_count          = 2'd1;
                  res0.event_res     = ifr_pkg::EV_DUP;
                  res0.reply_number  = ~expected_ff;
                  phase_in           = ifr_pkg::PH_WAIT;
               end else if (rx_byte == cfg.flag_byte) begin
                  phase_in = ifr_pkg::PH_FLAG;
               end else begin
                  phase_in = ifr_pkg::PH_WAIT;
               end
            end
            ifr_pkg::PH_CTRL: begin
               if (rx_byte == (cfg.address_value ^ accept_ctrl)) begin
                  phase_in      = ifr_pkg::PH_DATA;
                  esc_in        = 1'b0;
                  held_in       = 8'd0;
                  held_valid_in = 1'b0;
                  check_in      = 8'd0;
                  count_in      = '0;
               end else if (rx_byte == cfg.flag_byte) begin
                  phase_in = ifr_pkg::PH_FLAG;
               end else begin
                  phase_in = ifr_pkg::PH_WAIT;
               end
            end
            ifr_pkg::PH_DATA: begin
               if (esc_ff) begin
                  esc_in        = 1'b0;
                  held_valid_in = 1'b1;
                  if (held_valid_ff) begin
                     res_count = 2'd1;
                     res0      = ifr_pkg::make_data(held_ff);
                  end
                  if (rx_byte == cfg.escaped_flag_code) begin
                     held_in  = cfg.flag_byte;
                     check_in = check_ff ^ cfg.flag_byte;
                     count_in = ifr_pkg::inc_sat(count_ff);
                  end else if (rx_byte == cfg.escaped_escape_code) begin
                     held_in  = cfg.escape_byte;
                     check_in = check_ff ^ cfg.escape_byte;
                     count_in = ifr_pkg::inc_sat(count_ff);
                  end else begin
                     // Unknown code: the escape byte itself and this byte are both payload.
                     if (held_valid_ff) begin
                        res_count = 2'd2;
                        res1      = ifr_pkg::make_data(cfg.escape_byte);
                     end else begin
                        res_count = 2'd1;
                        res0      = ifr_pkg::make_data(cfg.escape_byte);
                     end
                     held_in  = rx_byte;
                     check_in = check_ff ^ cfg.escape_byte ^ rx_byte;
                     count_in = ifr_pkg::inc_sat(ifr_pkg::inc_sat(count_ff));
                  end
               end else if (rx_byte == cfg.flag_byte) begin
                  res_count         = 2'd1;
                  res0.reply_number = expected_ff;
                  if (frame_good) begin
                     res0.event_res      = ifr_pkg::EV_GOOD;
                     res0.payload_length = ifr_pkg::LEN_W'(count_less_one);
                     expected_in         = ~expected_ff;
                  end else begin
                     res0.event_res = ifr_pkg::EV_REJECT;
                  end
                  phase_in      = ifr_pkg::PH_WAIT;
                  esc_in        = 1'b0;
                  held_in       = 8'd0;
                  held_valid_in = 1'b0;
                  check_in      = 8'd0;
                  count_in      = '0;
               end else if (rx_byte == cfg.escape_byte) begin
                  esc_in = 1'b1;
               end else begin
                  if (held_valid_ff) begin
                     res_count = 2'd1;
                     res0      = ifr_pkg::make_data(held_ff);
                  end
                  held_in       = rx_byte;
                  held_valid_in = 1'b1;
                  check_in      = check_ff ^ rx_byte;
                  count_in      = ifr_pkg::inc_sat(count_ff);
               end
            end
            default: begin
               phase_in = ifr_pkg::PH_WAIT;
               if (rx_byte == cfg.flag_byte) begin
                  phase_in      = ifr_pkg::PH_FLAG;
                  esc_in        = 1'b0;
                  held_in       = 8'd0;
                  held_valid_in = 1'b0;
                  check_in      = 8'd0;
                  count_in      = '0;
               end
            end
         endcase
      end

      if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end else if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ifr_pkg::PH_WAIT;
         expected_ff   <= 1'b0;
         esc_ff        <= 1'b0;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         check_ff      <= 8'd0;
         count_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         expected_ff   <= expected_in;
         esc_ff        <= esc_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         check_ff      <= check_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ifr_result_fifo.sv
`default_nettype none

// Small result queue: takes zero, one or two results per cycle, gives one per pop while non-empty.
module ifr_result_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire [1:0]                push_count,
   input  wire ifr_pkg::result_type push0,
   input  wire ifr_pkg::result_type push1,
   input  wire                      pop,
   output ifr_pkg::result_type      head,
   output logic                     head_valid,
   output ifr_pkg::fifo_status_type status
);

   ifr_pkg::result_type           mem [ifr_pkg::FIFO_DEPTH];
   logic [ifr_pkg::PTR_W-1:0]     wr_ff, wr_in;
   logic [ifr_pkg::PTR_W-1:0]     rd_ff, rd_in;
   logic [ifr_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic                          do_pop;

   assign head_valid  = (fill_ff != '0);
   assign head        = mem[rd_ff];
   assign do_pop      = pop && head_valid;
   assign status.fill = fill_ff;
   // Room for the largest burst one transaction can cause.
   assign status.room = (fill_ff <= ifr_pkg::FILL_W'(ifr_pkg::FIFO_DEPTH - 2));

   always_comb begin
      wr_in   = wr_ff + ifr_pkg::PTR_W'(push_count);
      rd_in   = rd_ff + ifr_pkg::PTR_W'(do_pop);
      fill_in = fill_ff + ifr_pkg::FILL_W'(push_count) - ifr_pkg::FILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push_count != 2'd0) begin
         mem[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_ff + ifr_pkg::PTR_W'(1)] <= push1;
      end
   end

endmodule

`default_nettype wire

// File: rtl/info_frame_receiver.sv
// Information-frame receiver for a flag-delimited, byte-stuffed link.
// The req channel carries one received link byte per transaction (rx_byte).
// The rsp channel carries results: destuffed payload bytes (event 0), and at
// the closing flag a frame-good (1) or rejected (2, bad check or length) event, or a
// duplicate event (3) at the control byte of a repeated frame.
// One input byte causes zero, one or two results; last marks the final one.
// A result is presented on rsp in the cycle after the byte's transaction
// when no earlier result is still waiting in the queue.
// Throughput: one byte per cycle while each byte gives at most one result and
// the consumer keeps up; a byte that gives two results has both held by the
// four-entry result queue until the rsp side takes them.
// req ready is high whenever the queue has room for two results, so a new byte
// is taken while earlier results still wait to be read.
// When the consumer stalls, the queue fills and req ready drops once three or
// four results are buffered; nothing is lost or reordered.
// Reset (synchronous, active high) returns the frame logic to waiting for an
// opening flag, clears the sequence bit, empties the queue and loads the
// default link bytes into the configuration registers.
// Configuration registers are written through csr_we/csr_index/csr_wdata; the user
// must do so only while no transaction is in flight, which the block does not enforce.
`default_nettype none
`include "assert_macros.svh"

module info_frame_receiver (
   input  wire                            clock,
   input  wire                            reset,
   ifr_req_chan.sink                      req_chan,
   ifr_rsp_chan.source                    rsp_chan,
   input  wire                            csr_we,
   input  wire [ifr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [7:0]                      csr_wdata
);

   ifr_pkg::config_type       cfg_ff, cfg_in;
   logic                      req_accept;
   logic [1:0]                res_count;
   ifr_pkg::result_type       res0;
   ifr_pkg::result_type       res1;
   ifr_pkg::result_type       head;
   logic                      head_valid;
   ifr_pkg::fifo_status_type  fifo_status;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ifr_pkg::CSR_FLAG:      cfg_in.flag_byte           = csr_wdata;
            ifr_pkg::CSR_ESCAPE:    cfg_in.escape_byte         = csr_wdata;
            ifr_pkg::CSR_ESC_FLAG:  cfg_in.escaped_flag_code   = csr_wdata;
            ifr_pkg::CSR_ESC_ESC:   cfg_in.escaped_escape_code = csr_wdata;
            ifr_pkg::CSR_ADDRESS:   cfg_in.address_value       = csr_wdata;
            ifr_pkg::CSR_CTRL_ZERO: cfg_in.control_zero        = csr_wdata;
            ifr_pkg::CSR_CTRL_ONE:  cfg_in.control_one         = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte           <= 8'd126;
         cfg_ff.escape_byte         <= 8'd125;
         cfg_ff.escaped_flag_code   <= 8'd94;
         cfg_ff.escaped_escape_code <= 8'd93;
         cfg_ff.address_value       <= 8'd3;
         cfg_ff.control_zero        <= 8'd0;
         cfg_ff.control_one         <= 8'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A byte is taken whenever the result queue can hold its worst case.
   assign req_chan.ready = fifo_status.room;
   assign req_accept     = req_chan.valid && fifo_status.room;

   ifr_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_chan.rx_byte),
      .cfg       (cfg_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   ifr_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push0      (res0),
      .push1      (res1),
      .pop        (rsp_chan.ready),
      .head       (head),
      .head_valid (head_valid),
      .status     (fifo_status)
   );

   assign rsp_chan.valid          = head_valid;
   assign rsp_chan.event_res      = head.event_res;
   assign rsp_chan.data_byte      = head.data_byte;
   assign rsp_chan.reply_number   = head.reply_number;
   assign rsp_chan.payload_length = head.payload_length;
   assign rsp_chan.last           = head.last;

   // The queue never holds more than its depth.
   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1,
                   fifo_status.fill <= ifr_pkg::FILL_W'(ifr_pkg::FIFO_DEPTH),
                   "result queue overflow")

   // Frame events are always the final result of their byte.
   `ASSERT_IMPLIES(a_event_last, clock, reset,
                   rsp_chan.valid && (head.event_res != ifr_pkg::EV_DATA),
                   rsp_chan.last, "frame event not marked last")

   // Payload results carry no reply number and no length.
   `ASSERT_IMPLIES(a_data_clean, clock, reset,
                   rsp_chan.valid && (head.event_res == ifr_pkg::EV_DATA),
                   !rsp_chan.reply_number && (rsp_chan.payload_length == '0),
                   "payload result with reply fields set")

   // An accepted byte that causes results makes the queue non-empty next cycle.
   `ASSERT_NEXT(a_push_visible, clock, reset,
                req_accept && (res_count != 2'd0), rsp_chan.valid,
                "pushed result not visible")

endmodule

`default_nettype wire
